// ===== hdl/ethernet_ipv4_header_parser_core_macros.svh =====
// Assertion helpers for the header parser
`ifndef ETHERNET_IPV4_HEADER_PARSER_CORE_MACROS_SVH
`define ETHERNET_IPV4_HEADER_PARSER_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define EHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define EHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ehp_pkg.sv =====
`default_nettype none
package ehp_pkg;

  localparam int unsigned CodeW  = 6;
  localparam int unsigned ValueW = 48;
  localparam int unsigned DepthW = 4;
  localparam int unsigned FrameW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MaxRes = 4;
  localparam int unsigned ResCntW = 3;

  localparam logic [CfgIdxW-1:0] CfgVlanTpid = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgQinqTpid = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDnsPort  = 2'd2;

  localparam logic [15:0] VlanTpidReset = 16'h8100;
  localparam logic [15:0] QinqTpidReset = 16'h88a8;
  localparam logic [15:0] DnsPortReset  = 16'd53;

  localparam int unsigned QueueDepth = 4;

  localparam logic [CodeW-1:0] CodeOptByte = 6'd62;
  localparam logic [CodeW-1:0] CodePayload = 6'd63;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [ValueW-1:0] value;
  } res_t;

  // One byte's worth of results: the front end's output
  typedef struct packed {
    logic [ResCntW-1:0]       count;
    res_t [MaxRes-1:0]        res;
    logic [DepthW-1:0]        depth;
    logic [FrameW-1:0]        frame;
    logic                     eof;
  } batch_t;

endpackage
`default_nettype wire

// ===== hdl/ehp_front.sv =====
`default_nettype none
module ehp_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic [15:0]           vlan_tpid_i,
  input  wire logic [15:0]           qinq_tpid_i,
  input  wire logic [15:0]           dns_port_i,
  output ehp_pkg::batch_t            batch_o
);
  import ehp_pkg::*;

  typedef enum logic [5:0] {
    PhDmac, PhSmac, PhType, PhTci, PhItype,
    PhAhrd, PhApro, PhAhln, PhApln, PhAop, PhAsha, PhAspa, PhAtha, PhAtpa,
    PhVihl, PhTos, PhLen, PhId, PhOff, PhTtl, PhProto, PhCsum, PhSrc, PhDst,
    PhIpopt,
    PhTsp, PhTdp, PhSeq, PhAck, PhToff, PhWin, PhTsum, PhUrp, PhTcpopt,
    PhUsp, PhUdp, PhUlen, PhUsum,
    PhDid, PhDfl, PhDqd, PhDan, PhDns, PhDar,
    PhIty, PhIco, PhIcs, PhIrest,
    PhGty, PhGmr, PhGcs, PhGgrp,
    PhPay
  } phase_e;

  phase_e         ph_q, ph_d;
  logic [3:0]     fbc_q, fbc_d;
  logic [47:0]    acc_q, acc_d;
  logic [3:0]     tags_q, tags_d;
  logic [5:0]     ihl_q, ihl_d;
  logic [15:0]    tlen_q, tlen_d;
  logic [7:0]     proto_q, proto_d;
  logic [5:0]     thl_q, thl_d;
  logic           dns_q, dns_d;
  logic [5:0]     skip_q, skip_d;
  logic [15:0]    pay_q, pay_d;
  logic [7:0]     icmp_q, icmp_d;
  logic [15:0]    sport_q, sport_d;
  logic [31:0]    pkt_q, pkt_d;

  function automatic logic [3:0] plen(phase_e p);
    case (p)
      PhDmac, PhSmac, PhAsha, PhAtha: plen = 4'd6;
      PhAspa, PhAtpa, PhSrc, PhDst, PhSeq, PhAck, PhIrest, PhGgrp: plen = 4'd4;
      PhAhln, PhApln, PhVihl, PhTos, PhTtl, PhProto, PhIty, PhIco, PhGty, PhGmr:
        plen = 4'd1;
      default: plen = 4'd2;
    endcase
  endfunction

  function automatic logic [5:0] code_of(phase_e p);
    case (p)
      PhDmac: code_of = 6'd0;   PhSmac: code_of = 6'd1;   PhType: code_of = 6'd2;
      PhItype: code_of = 6'd6;  PhAhrd: code_of = 6'd7;   PhApro: code_of = 6'd8;
      PhAhln: code_of = 6'd9;   PhApln: code_of = 6'd10;  PhAop: code_of = 6'd11;
      PhAsha: code_of = 6'd12;  PhAspa: code_of = 6'd13;  PhAtha: code_of = 6'd14;
      PhAtpa: code_of = 6'd15;  PhTos: code_of = 6'd18;   PhLen: code_of = 6'd19;
      PhId: code_of = 6'd20;    PhTtl: code_of = 6'd23;   PhProto: code_of = 6'd24;
      PhCsum: code_of = 6'd25;  PhSrc: code_of = 6'd26;   PhDst: code_of = 6'd27;
      PhTsp: code_of = 6'd28;   PhTdp: code_of = 6'd29;   PhSeq: code_of = 6'd30;
      PhAck: code_of = 6'd31;   PhWin: code_of = 6'd34;   PhTsum: code_of = 6'd35;
      PhUrp: code_of = 6'd36;   PhUsp: code_of = 6'd37;   PhUdp: code_of = 6'd38;
      PhUlen: code_of = 6'd39;  PhUsum: code_of = 6'd40;  PhDid: code_of = 6'd41;
      PhDqd: code_of = 6'd44;   PhDan: code_of = 6'd45;   PhDns: code_of = 6'd46;
      PhDar: code_of = 6'd47;   PhIty: code_of = 6'd48;   PhIco: code_of = 6'd49;
      PhIcs: code_of = 6'd50;   PhGty: code_of = 6'd54;   PhGmr: code_of = 6'd55;
      PhGcs: code_of = 6'd56;   PhGgrp: code_of = 6'd57;
      default: code_of = 6'd0;
    endcase
  endfunction

  always_comb begin
    logic        sof;
    logic [47:0] v;
    logic [3:0]  fbn;
    logic [17:0] p;
    logic        fin;
    logic        eof;
    logic [2:0]  n;
    res_t [MaxRes-1:0] r;
    ph_d = ph_q; fbc_d = fbc_q; acc_d = acc_q; tags_d = tags_q; ihl_d = ihl_q;
    tlen_d = tlen_q; proto_d = proto_q; thl_d = thl_q; dns_d = dns_q;
    skip_d = skip_q; pay_d = pay_q; icmp_d = icmp_q; sport_d = sport_q;
    pkt_d = pkt_q;
    n = '0; r = '0; eof = 1'b0; fin = 1'b0; v = '0; fbn = '0; p = '0;
    sof = (ph_q == PhDmac) && (fbc_q == 4'd0);
    if (sof) begin
      pkt_d = pkt_q + 32'd1;
      tags_d = '0; dns_d = 1'b0; ihl_d = '0; tlen_d = '0; proto_d = '0;
      thl_d = '0; skip_d = '0; pay_d = '0; icmp_d = '0; sport_d = '0;
      acc_d = '0;
    end
    if (ph_q == PhIpopt || ph_q == PhTcpopt) begin
      r[0] = '{code: CodeOptByte, value: {40'd0, data_byte_i}}; n = 3'd1;
      if (skip_d != '0) skip_d = skip_d - 6'd1;
      if (skip_d == '0) begin
        if (ph_q == PhIpopt) begin
          case (proto_d)
            8'd6: ph_d = PhTsp;
            8'd17: ph_d = PhUsp;
            8'd1: ph_d = PhIty;
            8'd2: ph_d = PhGty;
            default: begin thl_d = '0; fin = 1'b1; end
          endcase
        end else fin = 1'b1;
      end
    end else if (ph_q == PhPay) begin
      r[0] = '{code: CodePayload, value: {40'd0, data_byte_i}}; n = 3'd1;
      if (pay_d != '0) pay_d = pay_d - 16'd1;
      if (pay_d == '0) begin ph_d = PhDmac; eof = 1'b1; end
    end else begin
      v = {acc_d[39:0], data_byte_i};
      fbn = fbc_q + 4'd1;
      acc_d = v; fbc_d = fbn;
      if (fbn >= plen(ph_q)) begin
        acc_d = '0; fbc_d = '0;
        if (!(ph_q inside {PhTci, PhVihl, PhOff, PhToff, PhDfl, PhIrest})) begin
          r[0] = '{code: code_of(ph_q), value: v}; n = 3'd1;
        end
        case (ph_q)
          PhType, PhItype: begin
            if (v[15:0] == vlan_tpid_i || v[15:0] == qinq_tpid_i) ph_d = PhTci;
            else if (v[15:0] == 16'h0806 || v[15:0] == 16'h8035) ph_d = PhAhrd;
            else if (v[15:0] == 16'h0800) ph_d = PhVihl;
            else begin ph_d = PhDmac; eof = 1'b1; end
          end
          PhTci: begin
            if (tags_d != 4'd15) tags_d = tags_d + 4'd1;
            r[0] = '{code: 6'd3, value: {45'd0, v[15:13]}};
            r[1] = '{code: 6'd4, value: {47'd0, v[12]}};
            r[2] = '{code: 6'd5, value: {36'd0, v[11:0]}};
            n = 3'd3; ph_d = PhItype;
          end
          PhAtpa: begin ph_d = PhDmac; eof = 1'b1; end
          PhVihl: begin
            r[0] = '{code: 6'd16, value: {44'd0, v[7:4]}};
            r[1] = '{code: 6'd17, value: {44'd0, v[3:0]}};
            n = 3'd2; ihl_d = {v[3:0], 2'b00}; ph_d = PhTos;
          end
          PhLen: begin tlen_d = v[15:0]; ph_d = PhId; end
          PhOff: begin
            r[0] = '{code: 6'd21, value: {45'd0, v[15:13]}};
            r[1] = '{code: 6'd22, value: {35'd0, v[12:0]}};
            n = 3'd2; ph_d = PhTtl;
          end
          PhProto: begin proto_d = v[7:0]; ph_d = PhCsum; end
          PhDst: begin
            if (ihl_d > 6'd20) begin skip_d = ihl_d - 6'd20; ph_d = PhIpopt; end
            else begin
              case (proto_d)
                8'd6: ph_d = PhTsp;
                8'd17: ph_d = PhUsp;
                8'd1: ph_d = PhIty;
                8'd2: ph_d = PhGty;
                default: begin thl_d = '0; fin = 1'b1; end
              endcase
            end
          end
          PhToff: begin
            r[0] = '{code: 6'd32, value: {44'd0, v[15:12]}};
            r[1] = '{code: 6'd33, value: {40'd0, v[7:0]}};
            n = 3'd2; thl_d = {v[15:12], 2'b00}; ph_d = PhWin;
          end
          PhUrp: begin
            if (thl_d > 6'd20) begin skip_d = thl_d - 6'd20; ph_d = PhTcpopt; end
            else fin = 1'b1;
          end
          PhUsp: begin sport_d = v[15:0]; ph_d = PhUdp; end
          PhUdp: begin
            dns_d = (sport_d == dns_port_i) || (v[15:0] == dns_port_i);
            ph_d = PhUlen;
          end
          PhUsum: begin
            thl_d = 6'd8;
            if (dns_d) ph_d = PhDid; else fin = 1'b1;
          end
          PhDfl: begin
            r[0] = '{code: 6'd42, value: v};
            r[1] = '{code: 6'd43, value: {47'd0, v[15]}};
            n = 3'd2; ph_d = PhDqd;
          end
          PhDar: fin = 1'b1;
          PhIty: begin icmp_d = v[7:0]; ph_d = PhIco; end
          PhIrest: begin
            if (icmp_d == 8'd0 || icmp_d == 8'd8) begin
              r[0] = '{code: 6'd51, value: {32'd0, v[31:16]}};
              r[1] = '{code: 6'd52, value: {32'd0, v[15:0]}};
              n = 3'd2;
            end else begin
              r[0] = '{code: 6'd53, value: {16'd0, v[31:0]}};
              n = 3'd1;
            end
            thl_d = 6'd8; fin = 1'b1;
          end
          PhGgrp: begin thl_d = 6'd8; fin = 1'b1; end
          default: ph_d = phase_e'(ph_q + 6'd1);
        endcase
      end
    end
    if (fin) begin
      p = {2'b00, tlen_d} - {12'd0, ihl_d} - {12'd0, thl_d} - (dns_d ? 18'd12 : 18'd0);
      if (!p[17] && p != '0) begin pay_d = p[15:0]; ph_d = PhPay; end
      else begin ph_d = PhDmac; eof = 1'b1; end
    end
    batch_o.count = n;
    batch_o.res   = r;
    batch_o.depth = tags_d;
    batch_o.frame = pkt_d;
    batch_o.eof   = eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhDmac; fbc_q <= '0; acc_q <= '0; tags_q <= '0; ihl_q <= '0;
      tlen_q <= '0; proto_q <= '0; thl_q <= '0; dns_q <= 1'b0; skip_q <= '0;
      pay_q <= '0; icmp_q <= '0; sport_q <= '0; pkt_q <= '0;
    end else if (step_i) begin
      ph_q <= ph_d; fbc_q <= fbc_d; acc_q <= acc_d; tags_q <= tags_d; ihl_q <= ihl_d;
      tlen_q <= tlen_d; proto_q <= proto_d; thl_q <= thl_d; dns_q <= dns_d;
      skip_q <= skip_d; pay_q <= pay_d; icmp_q <= icmp_d; sport_q <= sport_d;
      pkt_q <= pkt_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ehp_back.sv =====
`default_nettype none
`include "ethernet_ipv4_header_parser_core_macros.svh"
module ehp_back #(
  parameter int unsigned Depth = ehp_pkg::QueueDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire ehp_pkg::batch_t             batch_i,
  output logic                             full_o,
  input  wire logic                        pop_i,
  output logic                             empty_o,
  output logic [ehp_pkg::CodeW-1:0]        field_code_o,
  output logic [ehp_pkg::ValueW-1:0]       field_value_o,
  output logic [ehp_pkg::DepthW-1:0]       vlan_depth_o,
  output logic [ehp_pkg::FrameW-1:0]       frame_number_o,
  output logic                             end_of_frame_o,
  output logic                             last_of_run_o
);
  import ehp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  batch_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic [ResCntW-1:0] sub_q;
  batch_t          head;
  logic            head_ok;
  logic            take;
  logic            last_sub;

  // Batches with no results are dropped at the door
  logic wr_en;
  assign wr_en = push_i && !full_o && (batch_i.count != '0);
  assign full_o = (cnt_q == (PtrW+1)'(Depth));
  assign head = mem_q[rd_q];
  assign head_ok = (cnt_q != '0);
  assign empty_o = !head_ok;
  assign take = pop_i && head_ok;
  assign last_sub = ((sub_q + ResCntW'(1)) == head.count);

  assign field_code_o   = head.res[sub_q[1:0]].code;
  assign field_value_o  = head.res[sub_q[1:0]].value;
  assign vlan_depth_o   = head.depth;
  assign frame_number_o = head.frame;
  assign last_of_run_o  = last_sub;
  assign end_of_frame_o = last_sub && head.eof;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= batch_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0; sub_q <= '0;
    end else begin
      if (wr_en) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + PtrW'(1);
      if (take && last_sub) begin
        rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + PtrW'(1);
        sub_q <= '0;
      end else if (take) begin
        sub_q <= sub_q + ResCntW'(1);
      end
      cnt_q <= cnt_q + (PtrW+1)'(wr_en) - (PtrW+1)'(take && last_sub);
    end
  end

  `EHP_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, full_o, !wr_en, "write while full")
  `EHP_ASSERT_IMP(a_sub_range, clk_i, rst_ni, head_ok, sub_q < head.count,
    "result index beyond batch")
  `EHP_ASSERT_IMP(a_eof_last, clk_i, rst_ni, end_of_frame_o, last_of_run_o,
    "frame end not on last result")
  `EHP_ASSERT_NEXT(a_idle_hold, clk_i, rst_ni, !wr_en && !(take && last_sub),
    $stable(cnt_q), "occupancy moved without a transaction")

endmodule
`default_nettype wire

// ===== hdl/ethernet_ipv4_header_parser_core.sv =====
`default_nettype none
// Byte-stream header parser for Ethernet, stacked VLAN, ARP/RARP and IPv4 with
// TCP, UDP/DNS, ICMP and IGMP. One byte is taken per clock while the result
// queue has room; the front parser decodes each byte in that cycle and lands
// its 1 to 3 tagged results, if any, as one entry in a small queue. Results
// leave one per clock in order while pop is held, so a byte yielding several
// results takes one pop per result; a sustained one-result-per-byte stream
// runs at one byte per cycle, bounded by the single result port. Config writes
// are always ready and should only be issued while the block is idle.
module ethernet_ipv4_header_parser_core #(
  parameter int unsigned QueueDepth = ehp_pkg::QueueDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [7:0]                     data_byte_i,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [ehp_pkg::CodeW-1:0]           field_code_o,
  output logic [ehp_pkg::ValueW-1:0]          field_value_o,
  output logic [ehp_pkg::DepthW-1:0]          vlan_depth_o,
  output logic [ehp_pkg::FrameW-1:0]          frame_number_o,
  output logic                                end_of_frame_o,
  output logic                                last_of_run_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ehp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [ehp_pkg::CfgDataW-1:0]   cfg_data_i
);
  import ehp_pkg::*;

  logic [15:0] vlan_q, qinq_q, dns_q;
  batch_t      batch;
  logic        step;

  assign cfg_ready_o = 1'b1;
  assign step = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlan_q <= VlanTpidReset; qinq_q <= QinqTpidReset; dns_q <= DnsPortReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgVlanTpid: vlan_q <= cfg_data_i;
        CfgQinqTpid: qinq_q <= cfg_data_i;
        CfgDnsPort:  dns_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ehp_front u_front (
    .clk_i, .rst_ni, .step_i(step), .data_byte_i,
    .vlan_tpid_i(vlan_q), .qinq_tpid_i(qinq_q), .dns_port_i(dns_q),
    .batch_o(batch)
  );

  ehp_back #(.Depth(QueueDepth)) u_back (
    .clk_i, .rst_ni, .push_i(push), .batch_i(batch), .full_o(full),
    .pop_i(pop), .empty_o(empty), .field_code_o, .field_value_o,
    .vlan_depth_o, .frame_number_o, .end_of_frame_o, .last_of_run_o
  );

endmodule
`default_nettype wire
